// File: rtl/life_automaton_grid_core_assert.svh
// Assertion macros shared by the life automaton grid RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef LIFE_AUTOMATON_GRID_CORE_ASSERT_SVH
`define LIFE_AUTOMATON_GRID_CORE_ASSERT_SVH

// Antecedent holds in this cycle, consequent in the same cycle.
`define LAG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent holds in this cycle, consequent in the next cycle.
`define LAG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lag_pkg.sv
// Shared types and constants of the life automaton grid core.
// Depends on nothing; used by all modules in this folder.
package lag_pkg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR_MOD,
        ST_RD_DATA,
        ST_GEN,
        ST_DONE
    } state_t;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_STEP  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [1:0] REG_WRAP  = 2'd0;
    localparam logic [1:0] REG_RED   = 2'd1;
    localparam logic [1:0] REG_GREEN = 2'd2;
    localparam logic [1:0] REG_BLUE  = 2'd3;

    localparam logic       WRAP_RESET  = 1'b1;
    localparam logic [7:0] RED_RESET   = 8'd200;
    localparam logic [7:0] GREEN_RESET = 8'd0;
    localparam logic [7:0] BLUE_RESET  = 8'd0;

    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_req_t;

endpackage

// File: rtl/life_automaton_grid_core.sv
// Top level of the life automaton grid: control, registers and result stage.
// Depends on lag_pkg, lag_grid_mem, lag_row_rule and the assertion header.
//
//  channel   | valid     | ready     | payload
//  ----------+-----------+-----------+---------------------------------
//  in        | in_valid  | in_ready  | mode, column, row, cell_value
//  out       | out_valid | out_ready | cell_alive, red, green, blue
//  config    | psel      | pready    | penable, pwrite, paddr, pwdata, prdata
//
// The grid lives in one memory as rows of GRID_COLUMNS bits, in two banks.
// A cell write reads its row and writes it back with the cell changed; a cell read
// reads its row. An advance reads each row and the two wrapped-in rows, writing each
// new row to the other bank. After reset, bank 0 is cleared before in_ready rises.
// in_ready is high in idle even while a result waits in the output register.
`include "life_automaton_grid_core_assert.svh"

module life_automaton_grid_core #(
    parameter int GRID_COLUMNS = 64,
    parameter int GRID_ROWS    = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [5:0]  column,
    input  logic [4:0]  row,
    input  logic        cell_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        cell_alive,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int COL_W  = $clog2(GRID_COLUMNS);
    localparam int ROW_W  = $clog2(GRID_ROWS);
    localparam int K_W    = $clog2(GRID_ROWS + 3);
    localparam int ADDR_W = ROW_W + 1;

    localparam logic [K_W-1:0]   K_FIRST_OUT = K_W'(2);
    localparam logic [K_W-1:0]   K_LAST      = K_W'(GRID_ROWS + 1);
    localparam logic [K_W-1:0]   K_END       = K_W'(GRID_ROWS + 2);
    localparam logic [ROW_W-1:0] ROW_LAST    = ROW_W'(GRID_ROWS - 1);

    lag_pkg::state_t state_reg, state_next;

    logic              bank_reg, bank_next;
    logic              wrap_reg;
    logic [7:0]        red_cfg_reg, green_cfg_reg, blue_cfg_reg;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              value_reg, value_next;
    logic              res_alive_reg, res_alive_next;
    logic              res_pix_reg, res_pix_next;
    logic [ROW_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [K_W-1:0]    issue_k_reg, issue_k_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [K_W-1:0]    rd_k_reg, rd_k_next;
    logic [GRID_COLUMNS-1:0] win_up_reg, win_up_next;
    logic [GRID_COLUMNS-1:0] win_mid_reg, win_mid_next;
    logic              out_valid_reg, out_valid_next;
    logic              cell_alive_reg, cell_alive_next;
    logic [7:0]        red_reg, red_next;
    logic [7:0]        green_reg, green_next;
    logic [7:0]        blue_reg, blue_next;

    lag_pkg::mem_req_t       mem_req;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [ADDR_W-1:0]       mem_raddr;
    logic [GRID_COLUMNS-1:0] mem_wdata;
    logic [GRID_COLUMNS-1:0] mem_rdata;

    logic                    in_xfer;
    logic                    in_inside;
    logic                    slot_free;
    logic                    issuing;
    logic                    gen_last;
    logic                    edge_row;
    logic [ROW_W-1:0]        gen_row;
    logic [GRID_COLUMNS-1:0] row_in;
    logic [GRID_COLUMNS-1:0] row_new;
    logic [GRID_COLUMNS-1:0] row_mod;
    logic                    cfg_write;

    lag_grid_mem #(
        .WIDTH  (GRID_COLUMNS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .req   (mem_req),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    lag_row_rule #(
        .COLUMNS (GRID_COLUMNS)
    ) u_rule (
        .wrap    (wrap_reg),
        .row_up  (win_up_reg),
        .row_mid (win_mid_reg),
        .row_dn  (row_in),
        .row_new (row_new)
    );

    // ---------------------------------------------------------------- config port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_reg      <= lag_pkg::WRAP_RESET;
            red_cfg_reg   <= lag_pkg::RED_RESET;
            green_cfg_reg <= lag_pkg::GREEN_RESET;
            blue_cfg_reg  <= lag_pkg::BLUE_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                lag_pkg::REG_WRAP:  wrap_reg      <= pwdata[0];
                lag_pkg::REG_RED:   red_cfg_reg   <= pwdata[7:0];
                lag_pkg::REG_GREEN: green_cfg_reg <= pwdata[7:0];
                lag_pkg::REG_BLUE:  blue_cfg_reg  <= pwdata[7:0];
                default:            wrap_reg      <= wrap_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            lag_pkg::REG_WRAP:  prdata = {31'd0, wrap_reg};
            lag_pkg::REG_RED:   prdata = {24'd0, red_cfg_reg};
            lag_pkg::REG_GREEN: prdata = {24'd0, green_cfg_reg};
            lag_pkg::REG_BLUE:  prdata = {24'd0, blue_cfg_reg};
            default:            prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------- helpers
    assign in_ready  = (state_reg == lag_pkg::ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign in_inside = (32'(column) < GRID_COLUMNS) && (32'(row) < GRID_ROWS);
    assign slot_free = !out_valid_reg || out_ready;

    assign issuing  = (state_reg == lag_pkg::ST_GEN) && (issue_k_reg != K_END);
    assign gen_last = rd_vld_reg && (rd_k_reg == K_LAST);

    // Reads in an advance run over last row, rows 0 to last, then row 0 again,
    // so that every row sees both neighbors with the torus closed.
    always_comb
    begin
        if (issue_k_reg == '0)
        begin
            gen_row = ROW_LAST;
        end
        else if (issue_k_reg == K_LAST)
        begin
            gen_row = '0;
        end
        else
        begin
            gen_row = ROW_W'(issue_k_reg - K_W'(1));
        end
    end

    // The two wrapped-in rows are dead when the edges are not joined.
    assign edge_row = (rd_k_reg == '0) || (rd_k_reg == K_LAST);
    assign row_in   = (edge_row && !wrap_reg) ? '0 : mem_rdata;

    always_comb
    begin
        row_mod          = mem_rdata;
        row_mod[col_reg] = value_reg;
    end

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lag_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == ROW_LAST)
                begin
                    state_next = lag_pkg::ST_IDLE;
                end
            end
            lag_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (mode == lag_pkg::MODE_STEP)
                    begin
                        state_next = lag_pkg::ST_GEN;
                    end
                    else if (in_inside && (mode == lag_pkg::MODE_WRITE))
                    begin
                        state_next = lag_pkg::ST_WR_MOD;
                    end
                    else if (in_inside && (mode == lag_pkg::MODE_READ))
                    begin
                        state_next = lag_pkg::ST_RD_DATA;
                    end
                    else
                    begin
                        state_next = lag_pkg::ST_DONE;
                    end
                end
            end
            lag_pkg::ST_WR_MOD:  state_next = lag_pkg::ST_DONE;
            lag_pkg::ST_RD_DATA: state_next = lag_pkg::ST_DONE;
            lag_pkg::ST_GEN:
            begin
                if (gen_last)
                begin
                    state_next = lag_pkg::ST_DONE;
                end
            end
            lag_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = lag_pkg::ST_IDLE;
                end
            end
            default: state_next = lag_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- datapath and memory
    always_comb
    begin
        bank_next       = bank_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        value_next      = value_reg;
        res_alive_next  = res_alive_reg;
        res_pix_next    = res_pix_reg;
        clr_cnt_next    = clr_cnt_reg;
        issue_k_next    = issue_k_reg;
        rd_vld_next     = issuing;
        rd_k_next       = issue_k_reg;
        win_up_next     = win_up_reg;
        win_mid_next    = win_mid_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        cell_alive_next = cell_alive_reg;
        red_next        = red_reg;
        green_next      = green_reg;
        blue_next       = blue_reg;
        mem_req         = '0;
        mem_waddr       = '0;
        mem_raddr       = '0;
        mem_wdata       = '0;

        case (state_reg)
            lag_pkg::ST_CLEAR:
            begin
                mem_req.wr_en = 1'b1;
                mem_waddr     = {1'b0, clr_cnt_reg};
                clr_cnt_next  = clr_cnt_reg + ROW_W'(1);
            end
            lag_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    col_next       = COL_W'(column);
                    row_next       = ROW_W'(row);
                    value_next     = cell_value;
                    res_alive_next = 1'b0;
                    res_pix_next   = 1'b0;
                    issue_k_next   = '0;
                    if (in_inside && (mode == lag_pkg::MODE_WRITE))
                    begin
                        res_alive_next = cell_value;
                    end
                    if (in_inside && ((mode == lag_pkg::MODE_WRITE)
                                      || (mode == lag_pkg::MODE_READ)))
                    begin
                        mem_req.rd_en = 1'b1;
                        mem_raddr     = {bank_reg, ROW_W'(row)};
                    end
                end
            end
            lag_pkg::ST_WR_MOD:
            begin
                mem_req.wr_en = 1'b1;
                mem_waddr     = {bank_reg, row_reg};
                mem_wdata     = row_mod;
            end
            lag_pkg::ST_RD_DATA:
            begin
                res_alive_next = mem_rdata[col_reg];
                res_pix_next   = mem_rdata[col_reg];
            end
            lag_pkg::ST_GEN:
            begin
                if (issuing)
                begin
                    mem_req.rd_en = 1'b1;
                    mem_raddr     = {bank_reg, gen_row};
                    issue_k_next  = issue_k_reg + K_W'(1);
                end
                if (rd_vld_reg)
                begin
                    win_up_next  = win_mid_reg;
                    win_mid_next = row_in;
                    if (rd_k_reg >= K_FIRST_OUT)
                    begin
                        mem_req.wr_en = 1'b1;
                        mem_waddr     = {!bank_reg, ROW_W'(rd_k_reg - K_FIRST_OUT)};
                        mem_wdata     = row_new;
                    end
                end
                if (gen_last)
                begin
                    bank_next = !bank_reg;
                end
            end
            lag_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    cell_alive_next = res_alive_reg;
                    red_next        = res_pix_reg ? red_cfg_reg : 8'd0;
                    green_next      = res_pix_reg ? green_cfg_reg : 8'd0;
                    blue_next       = res_pix_reg ? blue_cfg_reg : 8'd0;
                end
            end
            default:
            begin
                mem_req = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lag_pkg::ST_CLEAR;
            bank_reg      <= 1'b0;
            clr_cnt_reg   <= '0;
            issue_k_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bank_reg      <= bank_next;
            clr_cnt_reg   <= clr_cnt_next;
            issue_k_reg   <= issue_k_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg        <= col_next;
        row_reg        <= row_next;
        value_reg      <= value_next;
        res_alive_reg  <= res_alive_next;
        res_pix_reg    <= res_pix_next;
        rd_k_reg       <= rd_k_next;
        win_up_reg     <= win_up_next;
        win_mid_reg    <= win_mid_next;
        cell_alive_reg <= cell_alive_next;
        red_reg        <= red_next;
        green_reg      <= green_next;
        blue_reg       <= blue_next;
    end

    assign out_valid  = out_valid_reg;
    assign cell_alive = cell_alive_reg;
    assign red        = red_reg;
    assign green      = green_reg;
    assign blue       = blue_reg;

    // ---------------------------------------------------------------- assertions
    `LAG_ASSERT_SAME(a_gen_writes_other_bank, clk, rst_n,
        (state_reg == lag_pkg::ST_GEN) && mem_req.wr_en,
        mem_waddr[ROW_W] != bank_reg,
        "advance wrote into the bank it is reading")
    `LAG_ASSERT_SAME(a_write_row_in_grid, clk, rst_n,
        mem_req.wr_en,
        32'(mem_waddr[ROW_W-1:0]) < GRID_ROWS,
        "memory write outside the grid rows")
    `LAG_ASSERT_NEXT(a_bank_flips_after_gen, clk, rst_n,
        (state_reg == lag_pkg::ST_GEN) && gen_last,
        (bank_reg != $past(bank_reg)) && (state_reg == lag_pkg::ST_DONE),
        "bank did not flip at the end of an advance")
    `LAG_ASSERT_NEXT(a_done_delivers, clk, rst_n,
        (state_reg == lag_pkg::ST_DONE) && slot_free,
        out_valid_reg && (state_reg == lag_pkg::ST_IDLE),
        "finished item did not reach the output register")

endmodule

// File: rtl/lag_grid_mem.sv
// Row-wide grid memory: one write port and one registered read port.
// Depends on lag_pkg for the request struct.
module lag_grid_mem #(
    parameter int WIDTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                 clk,
    input  lag_pkg::mem_req_t    req,
    input  logic [ADDR_W-1:0]    waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_W-1:0]    raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [2**ADDR_W];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/lag_row_rule.sv
// B3/S23 rule applied to one full row from a window of three rows.
// Depends on lag_pkg for the birth and survival counts.
module lag_row_rule #(
    parameter int COLUMNS = 64
) (
    input  logic               wrap,
    input  logic [COLUMNS-1:0] row_up,
    input  logic [COLUMNS-1:0] row_mid,
    input  logic [COLUMNS-1:0] row_dn,
    output logic [COLUMNS-1:0] row_new
);

    for (genvar c = 0; c < COLUMNS; c++)
    begin : g_col
        localparam int LEFT  = (c == 0) ? COLUMNS - 1 : c - 1;
        localparam int RIGHT = (c == COLUMNS - 1) ? 0 : c + 1;

        logic       keep_l;
        logic       keep_r;
        logic [3:0] count;

        // Neighbors across the left or right edge count only on a torus.
        assign keep_l = (c == 0) ? wrap : 1'b1;
        assign keep_r = (c == COLUMNS - 1) ? wrap : 1'b1;

        assign count = 4'(row_up[LEFT] & keep_l) + 4'(row_up[c]) + 4'(row_up[RIGHT] & keep_r)
                     + 4'(row_mid[LEFT] & keep_l) + 4'(row_mid[RIGHT] & keep_r)
                     + 4'(row_dn[LEFT] & keep_l) + 4'(row_dn[c]) + 4'(row_dn[RIGHT] & keep_r);

        assign row_new[c] = (count == lag_pkg::BIRTH_COUNT)
                          || (row_mid[c] && (count == lag_pkg::SURVIVE_COUNT));
    end

endmodule
